### rtl/assert_macros.svh
// Assertion macros used by the top level of the literal generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define HCLG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define HCLG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hclg_pkg.sv
// Package with constants and control types of the hashed clause literal generator.
package hclg_pkg;

  // Literals per clause and size of the variable pool.
  // NUM_VARS is kept a power of two, so the variable reduction is a mask.
  localparam int CLAUSE_WIDTH = 4;
  localparam int NUM_VARS     = 128;

  // Width of a stored variable (1 to NUM_VARS) and of the result field.
  localparam int VAR_W     = $clog2(NUM_VARS + 1);
  localparam int VAR_OUT_W = 13;

  // Width of the literal position inside a clause.
  localparam int POS_W = (CLAUSE_WIDTH > 1) ? $clog2(CLAUSE_WIDTH) : 1;

  // Stream payload widths.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request and form its first candidate
    logic step;    // move the candidate one variable up, with wrap
    logic commit;  // store the candidate and load the result register
  } hclg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // candidate matches an earlier variable of the clause
    logic last;      // current literal closes the clause
    logic pos_zero;  // no literal of a clause is pending
  } hclg_stat_t;

endpackage

### rtl/hashed_clause_literal_generator.sv
// Top level of the hashed clause literal generator: controller, datapath and checks.
//
//   Channel  Direction  Request contents
//   in_      slave      tdata: hash_word[15:0]; tlast: clause_end
//   out_     master     tdata: lit_var[12:0], positive[13]; tlast: last
//
// A request is taken in the idle state; the check state then compares the candidate
// against every earlier variable of the clause in parallel. Without a collision the
// check state commits the result unless the output stalls; each earlier variable that
// the candidate runs into adds one step of the candidate before the commit.
// Reset clears the state machine, result valid and literal position; no clearing pass.
// A new request is taken while a result still waits; a stalled output holds
// the controller in its compare state until the result register is read.
`include "assert_macros.svh"

module hashed_clause_literal_generator
  import hclg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] hash_word
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [12:0] lit_var, [13] positive, [15:14] zero
  output logic                  out_tlast
);

  hclg_cmd_t  cmd;
  hclg_stat_t stat;

  // Sequencing of requests and results.
  hclg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Candidate forming, collision compare and result register.
  hclg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // A result is only written into a free or draining result register.
  `HCLG_ASSERT(a_commit_free, cmd.commit |-> (!out_tvalid || out_tready), "commit over held result")
  // Only one request is in work at a time.
  `HCLG_ASSERT(a_one_in_work, (in_tvalid && in_tready) |=> !in_tready, "second request taken early")
  // Closing a clause returns the literal position to zero.
  `HCLG_ASSERT(a_clause_reset, (cmd.commit && stat.last) |=> stat.pos_zero, "clause not closed")
  // A colliding candidate is never committed.
  `HCLG_ASSERT_ALWAYS(a_no_dup, !(cmd.commit && stat.hit), "duplicate variable committed")

endmodule

### rtl/hclg_datapath.sv
// Datapath: candidate register, used-variable store, collision compare and result register.
module hclg_datapath
  import hclg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  hclg_cmd_t             cmd,
  output hclg_stat_t            stat,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic [VAR_W-1:0] cand_r;
  logic [VAR_W-1:0] cand_nxt;
  logic             pol_r;
  logic             end_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [VAR_W-1:0] used_r [CLAUSE_WIDTH];
  logic [VAR_W-1:0] out_var_r;
  logic             out_pol_r;
  logic             out_last_r;
  logic [14:0]      sel_idx;
  logic [14:0]      sel_rem;
  logic             hit;
  logic             last;

  // First candidate: the upper fifteen bits reduced into the pool, counted from one.
  assign sel_idx = in_tdata[15:1];
  assign sel_rem = sel_idx % 15'(NUM_VARS);

  // Compare the candidate against every variable already placed in this clause.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < CLAUSE_WIDTH; i++) begin
      if ((POS_W'(i) < pos_r) && (used_r[i] == cand_r)) begin
        hit = 1'b1;
      end
    end
  end

  // The clause closes on the flag or when its last position is reached.
  assign last = end_r || (pos_r == POS_W'(CLAUSE_WIDTH - 1));

  assign stat.hit      = hit;
  assign stat.last     = last;
  assign stat.pos_zero = (pos_r == '0);

  // Next candidate and next position.
  always_comb begin
    cand_nxt = cand_r;
    if (cmd.load) begin
      cand_nxt = VAR_W'(sel_rem) + VAR_W'(1);
    end else if (cmd.step) begin
      cand_nxt = (cand_r == VAR_W'(NUM_VARS)) ? VAR_W'(1) : cand_r + VAR_W'(1);
    end
    pos_nxt = pos_r;
    if (cmd.commit) begin
      pos_nxt = last ? '0 : pos_r + POS_W'(1);
    end
  end

  // Literal position is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Payload registers and the used-variable store.
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    if (cmd.load) begin
      pol_r <= in_tdata[0];
      end_r <= in_tlast;
    end
    if (cmd.commit) begin
      used_r[pos_r] <= cand_r;
      out_var_r     <= cand_r;
      out_pol_r     <= pol_r;
      out_last_r    <= last;
    end
  end

  // Result fields from the lowest bit up: lit_var, positive, zero fill.
  assign out_tdata = {2'b00, out_pol_r, VAR_OUT_W'(out_var_r)};
  assign out_tlast = out_last_r;

endmodule

### rtl/hclg_ctrl.sv
// Controller: request sequencing, collision retry loop and result valid flag.
module hclg_ctrl
  import hclg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  hclg_stat_t stat,
  output hclg_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_CHECK
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // The result register can take a new value when empty or being read.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Commands and next state.
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.hit) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and the registered result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
